@@ rtl/sorted_breakpoint_envelope_store_defines.svh @@
// Assertion macros shared by the block. Both expect clk and rst in scope.
`ifndef SORTED_BREAKPOINT_ENVELOPE_STORE_DEFINES_SVH
`define SORTED_BREAKPOINT_ENVELOPE_STORE_DEFINES_SVH

`define SBES_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SBES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sbes_pkg.sv @@
`timescale 1ns / 1ps
package sbes_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PAW = 4;

  localparam logic [1:0] REG_SMOOTH = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_CLR_RANGE = 2'd1,
    CMD_EVAL      = 2'd2,
    CMD_CLR_ALL   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SP_RDMID,
    OP_SP_CMP,
    OP_SP_RDLO,
    OP_SP_REPL,
    OP_SP_FULL,
    OP_SP_IDX,
    OP_SP_SHRD,
    OP_SP_SHWR,
    OP_SP_INS,
    OP_CR_RD,
    OP_CR_CHK,
    OP_CR_FIN,
    OP_CA,
    OP_EV_WRAP,
    OP_EV_WFIN,
    OP_EV_RD0,
    OP_EV_HOLD,
    OP_EV_RDN,
    OP_EV_SINIT,
    OP_EV_RDMID,
    OP_EV_SCMP,
    OP_EV_RDLO,
    OP_EV_RDHI,
    OP_EV_LATB,
    OP_EV_STEP,
    OP_EV_MUL,
    OP_EV_DIV,
    OP_EV_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic lo_lt_count;
    logic tick_hit;
    logic full;
    logic idx_gt_lo;
    logic idx_lt_count;
    logic count_zero;
    logic ct_le_tick;
    logic ct_ge_tick;
    logic ev_more;
    logic interp_ok;
    logic div_done;
    logic loop_on;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/sbes_ram.sv @@
`timescale 1ns / 1ps
module sbes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/sbes_div.sv @@
`timescale 1ns / 1ps
module sbes_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [15:0] remainder
);
  logic [5:0]  cnt;
  logic [15:0] dsr;
  logic [16:0] rem_sh;
  logic        fits;

  assign rem_sh = {remainder, quotient[31]};
  assign fits = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt       <= 6'd32;
        dsr       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (cnt != '0) begin
        cnt      <= cnt - 6'd1;
        quotient <= {quotient[30:0], fits};
        if (fits) begin
          remainder <= 16'(rem_sh - {1'b0, dsr});
        end else begin
          remainder <= rem_sh[15:0];
        end
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/sbes_dp.sv @@
`timescale 1ns / 1ps
`include "sorted_breakpoint_envelope_store_defines.svh"
module sbes_dp (
  input  logic           clk,
  input  logic           rst,
  input  sbes_pkg::ctl_t ctl,
  output sbes_pkg::stat_t stat,
  input  logic           smooth_mode,
  input  logic [15:0]    value_limit,
  input  logic [15:0]    loop_length,
  input  logic [15:0]    loop_offset,
  input  logic [15:0]    point_tick,
  input  logic [15:0]    range_end,
  input  logic [15:0]    point_value,
  input  logic [31:0]    eval_tick,
  input  logic [31:0]    clip_length,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           status,
  output logic           defined,
  output logic [15:0]    result_value
);
  import sbes_pkg::*;

  logic [CW-1:0] count, lo, hi, idx, w;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid, lo_inc, idx_dec, cnt_dec;
  logic [15:0]   ptick, rend, pval, ta, va, tb, vb;
  logic [31:0]   etick, clip, ct, prod;
  logic          neg, res_status, res_defined;
  logic [15:0]   res_value;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [15:0]   rd_tick, rd_val;
  logic          in_range;

  logic          div_start, div_done;
  logic [31:0]   div_dividend, div_quo;
  logic [15:0]   div_divisor, div_rem, win, absd, into;

  assign rd_tick  = ram_rdata[31:16];
  assign rd_val   = ram_rdata[15:0];
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[CW:1];
  assign lo_inc   = lo + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign cnt_dec  = count - CW'(1);
  assign in_range = (rd_tick >= ptick) && (rd_tick <= rend);

  assign win = ((clip != '0) && ({16'd0, loop_length} > clip)) ? clip[15:0] : loop_length;
  assign absd = (vb >= va) ? (vb - va) : (va - vb);
  assign into = ct[15:0] - ta;

  assign div_start    = ((ctl.op == OP_EV_WRAP) && (loop_length != '0)) ||
                        (ctl.op == OP_EV_DIV);
  assign div_dividend = (ctl.op == OP_EV_DIV) ? prod : etick;
  assign div_divisor  = (ctl.op == OP_EV_DIV) ? (tb - ta) : win;

  always_comb begin
    stat.lo_lt_hi     = lo < hi;
    stat.lo_lt_count  = lo < count;
    stat.tick_hit     = rd_tick == ptick;
    stat.full         = count >= CW'(MAX_POINTS);
    stat.idx_gt_lo    = idx > lo;
    stat.idx_lt_count = idx < count;
    stat.count_zero   = count == '0;
    stat.ct_le_tick   = ct <= {16'd0, rd_tick};
    stat.ct_ge_tick   = ct >= {16'd0, rd_tick};
    stat.ev_more      = lo_inc < hi;
    stat.interp_ok    = smooth_mode && (tb > ta);
    stat.div_done     = div_done;
    stat.loop_on      = loop_length != '0;
    stat.out_free     = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo[AW-1:0];
    ram_wdata = {ptick, pval};
    ram_raddr = lo[AW-1:0];
    case (ctl.op)
      OP_SP_RDMID, OP_EV_RDMID: ram_raddr = mid[AW-1:0];
      OP_SP_REPL, OP_SP_INS: ram_we = 1'b1;
      OP_SP_SHRD: ram_raddr = idx_dec[AW-1:0];
      OP_SP_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = ram_rdata;
      end
      OP_CR_RD: ram_raddr = idx[AW-1:0];
      OP_CR_CHK: begin
        ram_we    = !in_range;
        ram_waddr = w[AW-1:0];
        ram_wdata = ram_rdata;
      end
      OP_EV_RD0: ram_raddr = '0;
      OP_EV_RDN: ram_raddr = cnt_dec[AW-1:0];
      OP_EV_RDHI: ram_raddr = lo_inc[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (ctl.op != OP_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (ctl.op)
        OP_LOAD: begin
          ptick       <= point_tick;
          rend        <= range_end;
          pval        <= (point_value > value_limit) ? value_limit : point_value;
          etick       <= eval_tick;
          clip        <= clip_length;
          lo          <= '0;
          hi          <= count;
          idx         <= '0;
          w           <= '0;
          res_status  <= 1'b0;
          res_defined <= 1'b0;
          res_value   <= '0;
        end
        OP_SP_CMP: begin
          if (rd_tick < ptick) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
        end
        OP_SP_FULL: res_status <= 1'b1;
        OP_SP_IDX: idx <= count;
        OP_SP_SHWR: idx <= idx_dec;
        OP_SP_INS: count <= count + CW'(1);
        OP_CR_CHK: begin
          if (!in_range) begin
            w <= w + CW'(1);
          end
          idx <= idx + CW'(1);
        end
        OP_CR_FIN: count <= w;
        OP_CA: count <= '0;
        OP_EV_WRAP: ct <= etick;
        OP_EV_WFIN: ct <= 32'(loop_offset) + 32'(div_rem);
        OP_EV_HOLD: begin
          res_defined <= 1'b1;
          res_value   <= rd_val;
        end
        OP_EV_SINIT: begin
          lo <= '0;
          hi <= cnt_dec;
        end
        OP_EV_SCMP: begin
          if ({16'd0, rd_tick} <= ct) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
        end
        OP_EV_RDHI: begin
          ta <= rd_tick;
          va <= rd_val;
        end
        OP_EV_LATB: begin
          tb <= rd_tick;
          vb <= rd_val;
        end
        OP_EV_STEP: begin
          res_defined <= 1'b1;
          res_value   <= va;
        end
        OP_EV_MUL: begin
          prod <= absd * into;
          neg  <= vb < va;
        end
        OP_EV_FIN: begin
          res_defined <= 1'b1;
          res_value   <= neg ? (va - div_quo[15:0]) : (va + div_quo[15:0]);
        end
        OP_EMIT: begin
          out_valid    <= 1'b1;
          status       <= res_status;
          defined      <= res_defined;
          result_value <= res_value;
        end
        default: ;
      endcase
    end
  end

  sbes_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sbes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  `SBES_ASSERT_SAME(a_insert_not_full, ctl.op == OP_SP_INS, count < CW'(MAX_POINTS))
  `SBES_ASSERT_SAME(a_compact_shrinks, ctl.op == OP_CR_FIN, w <= count)
  `SBES_ASSERT_NEXT(a_emit_shows_beat, ctl.op == OP_EMIT, out_valid)
endmodule

@@ rtl/sbes_ctrl.sv @@
`timescale 1ns / 1ps
module sbes_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      cmd,
  input  sbes_pkg::stat_t stat,
  output sbes_pkg::ctl_t  ctl
);
  import sbes_pkg::*;

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_SP_SRCH  = 22'h000002,
    ST_SP_CMP   = 22'h000004,
    ST_SP_CHK   = 22'h000008,
    ST_SP_SHRD  = 22'h000010,
    ST_SP_SHWR  = 22'h000020,
    ST_CR_RD    = 22'h000040,
    ST_CR_CHK   = 22'h000080,
    ST_CA       = 22'h000100,
    ST_EV_WRAP  = 22'h000200,
    ST_EV_WDIV  = 22'h000400,
    ST_EV_FIRST = 22'h000800,
    ST_EV_F2    = 22'h001000,
    ST_EV_L2    = 22'h002000,
    ST_EV_SRCH  = 22'h004000,
    ST_EV_SCMP  = 22'h008000,
    ST_EV_RA    = 22'h010000,
    ST_EV_RB    = 22'h020000,
    ST_EV_MUL   = 22'h040000,
    ST_EV_DIVST = 22'h080000,
    ST_EV_IDIV  = 22'h100000,
    ST_DONE     = 22'h200000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.op = OP_LOAD;
          case (cmd_t'(cmd))
            CMD_SET:       state_next = ST_SP_SRCH;
            CMD_CLR_RANGE: state_next = ST_CR_RD;
            CMD_EVAL:      state_next = ST_EV_WRAP;
            CMD_CLR_ALL:   state_next = ST_CA;
            default:       state_next = ST_CA;
          endcase
        end
      end
      ST_SP_SRCH: begin
        if (stat.lo_lt_hi) begin
          ctl.op     = OP_SP_RDMID;
          state_next = ST_SP_CMP;
        end else begin
          ctl.op     = OP_SP_RDLO;
          state_next = ST_SP_CHK;
        end
      end
      ST_SP_CMP: begin
        ctl.op     = OP_SP_CMP;
        state_next = ST_SP_SRCH;
      end
      ST_SP_CHK: begin
        if (stat.lo_lt_count && stat.tick_hit) begin
          ctl.op     = OP_SP_REPL;
          state_next = ST_DONE;
        end else if (stat.full) begin
          ctl.op     = OP_SP_FULL;
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_SP_IDX;
          state_next = ST_SP_SHRD;
        end
      end
      ST_SP_SHRD: begin
        if (stat.idx_gt_lo) begin
          ctl.op     = OP_SP_SHRD;
          state_next = ST_SP_SHWR;
        end else begin
          ctl.op     = OP_SP_INS;
          state_next = ST_DONE;
        end
      end
      ST_SP_SHWR: begin
        ctl.op     = OP_SP_SHWR;
        state_next = ST_SP_SHRD;
      end
      ST_CR_RD: begin
        if (stat.idx_lt_count) begin
          ctl.op     = OP_CR_RD;
          state_next = ST_CR_CHK;
        end else begin
          ctl.op     = OP_CR_FIN;
          state_next = ST_DONE;
        end
      end
      ST_CR_CHK: begin
        ctl.op     = OP_CR_CHK;
        state_next = ST_CR_RD;
      end
      ST_CA: begin
        ctl.op     = OP_CA;
        state_next = ST_DONE;
      end
      ST_EV_WRAP: begin
        ctl.op     = OP_EV_WRAP;
        state_next = stat.loop_on ? ST_EV_WDIV : ST_EV_FIRST;
      end
      ST_EV_WDIV: begin
        if (stat.div_done) begin
          ctl.op     = OP_EV_WFIN;
          state_next = ST_EV_FIRST;
        end
      end
      ST_EV_FIRST: begin
        if (stat.count_zero) begin
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_EV_RD0;
          state_next = ST_EV_F2;
        end
      end
      ST_EV_F2: begin
        if (stat.ct_le_tick) begin
          ctl.op     = OP_EV_HOLD;
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_EV_RDN;
          state_next = ST_EV_L2;
        end
      end
      ST_EV_L2: begin
        if (stat.ct_ge_tick) begin
          ctl.op     = OP_EV_HOLD;
          state_next = ST_DONE;
        end else begin
          ctl.op     = OP_EV_SINIT;
          state_next = ST_EV_SRCH;
        end
      end
      ST_EV_SRCH: begin
        if (stat.ev_more) begin
          ctl.op     = OP_EV_RDMID;
          state_next = ST_EV_SCMP;
        end else begin
          ctl.op     = OP_EV_RDLO;
          state_next = ST_EV_RA;
        end
      end
      ST_EV_SCMP: begin
        ctl.op     = OP_EV_SCMP;
        state_next = ST_EV_SRCH;
      end
      ST_EV_RA: begin
        ctl.op     = OP_EV_RDHI;
        state_next = ST_EV_RB;
      end
      ST_EV_RB: begin
        ctl.op     = OP_EV_LATB;
        state_next = ST_EV_MUL;
      end
      ST_EV_MUL: begin
        if (stat.interp_ok) begin
          ctl.op     = OP_EV_MUL;
          state_next = ST_EV_DIVST;
        end else begin
          ctl.op     = OP_EV_STEP;
          state_next = ST_DONE;
        end
      end
      ST_EV_DIVST: begin
        ctl.op     = OP_EV_DIV;
        state_next = ST_EV_IDIV;
      end
      ST_EV_IDIV: begin
        if (stat.div_done) begin
          ctl.op     = OP_EV_FIN;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctl.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

@@ rtl/sorted_breakpoint_envelope_store.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Contents
// config    psel/penable/pready    smooth_mode, value_limit, loop_length, loop_offset
// input     in_valid/in_ready      cmd, point_tick, range_end, point_value, eval_tick,
//                                  clip_length
// output    out_valid/out_ready    status, defined, result_value
//
// One beat is taken at a time; the point list sits in a single-port-write RAM.
// The set point command shifts entries up by a read-then-write through the RAM.
// Evaluate uses the shared 32-step divider for the loop wrap and for interpolation.
// Reset is synchronous and empties the list; a stalled result holds the next beat
// in its final state until the output register is free.
module sorted_breakpoint_envelope_store (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [sbes_pkg::PAW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic [15:0]              point_tick,
  input  logic [15:0]              range_end,
  input  logic [15:0]              point_value,
  input  logic [31:0]              eval_tick,
  input  logic [31:0]              clip_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic                     defined,
  output logic [15:0]              result_value
);
  import sbes_pkg::*;

  logic        smooth_mode;
  logic [15:0] value_limit, loop_length, loop_offset;
  ctl_t        ctl;
  stat_t       stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_mode <= 1'b0;
      value_limit <= 16'hFFFF;
      loop_length <= '0;
      loop_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SMOOTH: smooth_mode <= pwdata[0];
        REG_LIMIT:  value_limit <= pwdata[15:0];
        REG_LENGTH: loop_length <= pwdata[15:0];
        REG_OFFSET: loop_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SMOOTH: prdata = 32'(smooth_mode);
      REG_LIMIT:  prdata = 32'(value_limit);
      REG_LENGTH: prdata = 32'(loop_length);
      REG_OFFSET: prdata = 32'(loop_offset);
      default:    prdata = '0;
    endcase
  end

  sbes_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat),
    .ctl     (ctl)
  );

  sbes_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .smooth_mode (smooth_mode),
    .value_limit (value_limit),
    .loop_length (loop_length),
    .loop_offset (loop_offset),
    .point_tick  (point_tick),
    .range_end   (range_end),
    .point_value (point_value),
    .eval_tick   (eval_tick),
    .clip_length (clip_length),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .defined     (defined),
    .result_value(result_value)
  );
endmodule
